// ----- rtl/core/sbd_pkg.sv -----
// Package: shared types and constants for the single-button dimmer control.
`timescale 1ns / 1ps
`default_nettype none

package sbd_pkg;

    // Default brightness register width
    localparam int LEVEL_BITS_DEF = 8;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_PERIOD = 1'd1;

    // Configuration reset values
    localparam logic [7:0] LONG_PRESS_RST  = 8'd15;
    localparam logic [7:0] RAMP_PERIOD_RST = 8'd5;

    // Tick counters saturate here
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Stream payload widths
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 16;

    typedef struct packed {
        logic [7:0] long_press_ticks;
        logic [7:0] ramp_period_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] pwm_duty;
        logic       lamp_on;
        logic       ramping_up;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/single_button_dimmer_control_unit.sv -----
// Top level: single-button dimmer control with stream ports and config port.
// Path: an item loads the input register at accept, and its result then loads
// the result register; an output stall can hold either register.
// Throughput: one item per cycle; the update logic is a single pass between
// the input register and the result register, both held only by output stall.
// Reset (i_rst_n low, synchronous): lamp off, level 1, direction up, counters
// clear, config back to long press 15 ticks and ramp period 5 ticks.
`timescale 1ns / 1ps
`default_nettype none

module single_button_dimmer_control_unit #(
    parameter int LEVEL_BITS = sbd_pkg::LEVEL_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input item stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [sbd_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,  // [0] button_pressed,
                                                                // [7:1] zero
    // result item stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [sbd_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,  // [7:0] pwm_duty,
                                                                // [8] lamp_on,
                                                                // [9] ramping_up,
                                                                // [15:10] zero
    // configuration write port
    input  wire         i_cfg_we,
    input  wire  [sbd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire  [7:0]  i_cfg_data
);

    // config registers
    sbd_pkg::t_cfg    r_cfg;

    // input register
    logic             r_in_valid;
    logic             r_in_btn;

    // result register
    logic             r_out_valid;
    sbd_pkg::t_result r_out;

    sbd_pkg::t_result w_result;
    logic             w_adv;      // result register can load
    logic             w_tick;     // a held item is applied to the state

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_tick          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks  <= sbd_pkg::LONG_PRESS_RST;
            r_cfg.ramp_period_ticks <= sbd_pkg::RAMP_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbd_pkg::REG_LONG_PRESS:  r_cfg.long_press_ticks  <= i_cfg_data;
                sbd_pkg::REG_RAMP_PERIOD: r_cfg.ramp_period_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage: loads whenever it is empty or its item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_btn <= i_s_axis_tdata[0];
        end
    end

    sbd_core #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_tick),
        .i_pressed (r_in_btn),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.ramping_up, r_out.lamp_on, r_out.pwm_duty};

    // An applied tick always yields a result next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_out_valid)
        else $error("tick applied but no result");

    // Input is refused only when both stages are full and output is stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("input refused without full stall");

    // Lamp off gives zero duty
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.lamp_on) |-> (r_out.pwm_duty == 8'd0))
        else $error("nonzero duty with lamp off");

endmodule

`default_nettype wire

// ----- rtl/core/sbd_core.sv -----
// Dimmer state registers and per-tick update logic.
`timescale 1ns / 1ps
`default_nettype none

module sbd_core #(
    parameter int LEVEL_BITS = sbd_pkg::LEVEL_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,       // one tick is applied
    input  wire                 i_pressed,
    input  wire sbd_pkg::t_cfg  i_cfg,
    output sbd_pkg::t_result    o_result    // result after this tick's update
);

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1);

    logic                  r_is_on, n_is_on;
    logic [LEVEL_BITS-1:0] r_brightness, n_brightness;
    logic                  r_dir_up, n_dir_up;
    logic [7:0]            r_hold, n_hold;
    logic [7:0]            r_step, n_step;
    logic                  r_in_ramp, n_in_ramp;
    logic                  r_btn_before;

    logic                  w_released;
    logic                  w_do_step;
    logic [LEVEL_BITS-1:0] w_stepped;

    assign w_released = r_btn_before && !i_pressed;

    // One brightness step in the current direction, clamped at the ends
    always_comb begin
        w_stepped = r_brightness;
        if (r_dir_up) begin
            if (r_brightness != LEVEL_MAX) begin
                w_stepped = {r_brightness[LEVEL_BITS-2:0], 1'b1};
            end
        end else begin
            if (r_brightness != LEVEL_ONE) begin
                w_stepped = r_brightness >> 1;
            end
        end
    end

    always_comb begin
        n_is_on   = r_is_on;
        n_dir_up  = r_dir_up;
        n_hold    = r_hold;
        n_step    = r_step;
        n_in_ramp = r_in_ramp;
        w_do_step = 1'b0;
        if (!r_is_on) begin
            n_hold    = '0;
            n_step    = '0;
            n_in_ramp = 1'b0;
            if (w_released) begin
                n_is_on = 1'b1;
            end
        end else if (i_pressed) begin
            if (!r_in_ramp) begin
                if (r_hold != sbd_pkg::COUNT_MAX) begin
                    n_hold = r_hold + 8'd1;
                end
                if (n_hold >= i_cfg.long_press_ticks) begin
                    n_in_ramp = 1'b1;
                    n_step    = '0;
                    w_do_step = 1'b1;
                end
            end else begin
                if (r_step != sbd_pkg::COUNT_MAX) begin
                    n_step = r_step + 8'd1;
                end
                if (n_step >= i_cfg.ramp_period_ticks) begin
                    n_step    = '0;
                    w_do_step = 1'b1;
                end
            end
        end else begin
            if (w_released) begin
                if (r_in_ramp) begin
                    n_in_ramp = 1'b0;
                    n_dir_up  = !r_dir_up;
                end else begin
                    n_is_on = 1'b0;
                end
            end
            n_hold = '0;
            n_step = '0;
        end
        n_brightness = w_do_step ? w_stepped : r_brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_on      <= 1'b0;
            r_brightness <= LEVEL_ONE;
            r_dir_up     <= 1'b1;
            r_hold       <= '0;
            r_step       <= '0;
            r_in_ramp    <= 1'b0;
            r_btn_before <= 1'b0;
        end else if (i_en) begin
            r_is_on      <= n_is_on;
            r_brightness <= n_brightness;
            r_dir_up     <= n_dir_up;
            r_hold       <= n_hold;
            r_step       <= n_step;
            r_in_ramp    <= n_in_ramp;
            r_btn_before <= i_pressed;
        end
    end

    assign o_result.pwm_duty   = n_is_on ? 8'(n_brightness) : 8'd0;
    assign o_result.lamp_on    = n_is_on;
    assign o_result.ramping_up = n_dir_up;

    // Level never reaches zero: stepping down stops at one
    a_level_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brightness != '0)
        else $error("brightness reached zero");

    // Ramping only happens with the lamp on
    a_ramp_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ramp |-> r_is_on)
        else $error("ramping while lamp off");

    // Counters sit at zero while the lamp is off
    a_off_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_is_on |-> (r_hold == '0 && r_step == '0))
        else $error("tick counters running with lamp off");

endmodule

`default_nettype wire
